// ===== sv/odo_pkg.sv =====
`timescale 1ns / 1ps

package odo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int QUO_BITS     = 73;
   localparam int SD_W         = 49;

   localparam logic [31:0] DIST_SCALE_RESET  = 32'd468508;
   localparam logic [39:0] ANGLE_SCALE_RESET = 40'd4886718346;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_BASE = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic REG_DIST_SCALE  = 1'b0;
   localparam logic REG_ANGLE_SCALE = 1'b1;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] heading;
      logic [31:0] right_wheel_scale;
      logic [31:0] left_wheel_scale;
      logic [30:0] wheel_base;
   } pass_type;

   typedef struct packed {
      pass_type        pass;
      logic [SD_W-1:0] sd_mag;
      logic            sd_neg;
      logic            diff_neg;
      logic [31:0]     new_heading;
   } item_type;

   typedef struct packed {
      logic [31:0] new_pos_x;
      logic [31:0] new_pos_y;
      logic [31:0] new_heading;
      logic [31:0] out_right_scale;
      logic [31:0] out_left_scale;
      logic [30:0] out_wheel_base;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [31:0] atan_of(input logic [4:0] k);
      logic [31:0] r;
      unique case (k)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         5'd31: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/differential_drive_odometry_update.sv =====
`timescale 1ns / 1ps
// pipeline: 8 multiply stages, 73 restoring divider stages at one quotient bit each,
// 25 cordic stages and 4 output stages lie between the req transaction and rsp_tvalid
// throughput: one transaction per cycle; the whole pipeline holds while rsp_tvalid waits
// reset: synchronous active high; clears all valid bits and loads the scale registers

module differential_drive_odometry_update import odo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, heading, right_wheel_scale, left_wheel_scale, wheel_base,
   // right_pulses, left_pulses, right_noise, left_noise, zero pad
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_heading, out_right_scale, out_left_scale,
   // out_wheel_base, status, zero pad
   output logic [199:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [31:0] dist_scale_ff;
   logic [39:0] angle_scale_ff;
   logic        adv;
   pass_type    req_pass;

   logic                fr_valid, dv_valid, cd_valid, bk_valid;
   item_type            fr_item, dv_item, cd_item;
   logic [QUO_BITS-1:0] fr_dividend;
   logic [31:0]         dv_quotient;
   logic signed [33:0]  cd_x, cd_y;
   logic [1:0]          cd_quad;
   rsp_type             bk_rsp;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == REG_ANGLE_SCALE) ? {24'b0, angle_scale_ff}
                                                       : {32'b0, dist_scale_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_scale_ff  <= DIST_SCALE_RESET;
         angle_scale_ff <= ANGLE_SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[3] == REG_DIST_SCALE) begin
            dist_scale_ff <= csr_pwdata[31:0];
         end else begin
            angle_scale_ff <= csr_pwdata[39:0];
         end
      end
   end

   assign adv        = !bk_valid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = bk_valid;

   always_comb begin
      req_pass.pos_x             = req_tdata[31:0];
      req_pass.pos_y             = req_tdata[63:32];
      req_pass.heading           = req_tdata[95:64];
      req_pass.right_wheel_scale = req_tdata[127:96];
      req_pass.left_wheel_scale  = req_tdata[159:128];
      req_pass.wheel_base        = req_tdata[190:160];
   end

   odo_front u_front (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_tvalid),
      .in_pass        (req_pass),
      .right_pulses   (req_tdata[206:191]),
      .left_pulses    (req_tdata[222:207]),
      .right_noise    (req_tdata[254:223]),
      .left_noise     (req_tdata[286:255]),
      .distance_scale (dist_scale_ff),
      .angle_scale    (angle_scale_ff),
      .out_valid      (fr_valid),
      .out_item       (fr_item),
      .out_dividend   (fr_dividend)
   );

   odo_div u_div (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (fr_valid),
      .in_item      (fr_item),
      .in_dividend  (fr_dividend),
      .out_valid    (dv_valid),
      .out_item     (dv_item),
      .out_quotient (dv_quotient)
   );

   odo_cordic u_cordic (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dv_valid),
      .in_item     (dv_item),
      .in_quotient (dv_quotient),
      .out_valid   (cd_valid),
      .out_item    (cd_item),
      .out_x       (cd_x),
      .out_y       (cd_y),
      .out_quad    (cd_quad)
   );

   odo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cd_valid),
      .in_item   (cd_item),
      .in_x      (cd_x),
      .in_y      (cd_y),
      .in_quad   (cd_quad),
      .out_valid (bk_valid),
      .out_rsp   (bk_rsp)
   );

   assign rsp_tdata = {7'b0, bk_rsp.status, bk_rsp.out_wheel_base, bk_rsp.out_left_scale,
                       bk_rsp.out_right_scale, bk_rsp.new_heading, bk_rsp.new_pos_y,
                       bk_rsp.new_pos_x};

endmodule

// ===== sv/odo_front.sv =====
`timescale 1ns / 1ps

module odo_front import odo_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  pass_type            in_pass,
   input  logic [15:0]         right_pulses,
   input  logic [15:0]         left_pulses,
   input  logic [31:0]         right_noise,
   input  logic [31:0]         left_noise,
   input  logic [31:0]         distance_scale,
   input  logic [39:0]         angle_scale,
   output logic                out_valid,
   output item_type            out_item,
   output logic [QUO_BITS-1:0] out_dividend
);

   logic [7:0] vld_ff;
   pass_type   pass_ff [8];

   // noisy counts
   logic signed [33:0] ur_ff, ul_ff, ur_in, ul_in;
   // magnitudes
   logic [32:0] mur_ff, mul_ff;
   logic [31:0] mrs_ff, mls_ff;
   logic        nr2_ff, nl2_ff;
   // wheel product magnitudes
   logic [64:0] prod_r, prod_l;
   logic [55:0] pr_ff, pl_ff;
   logic        nr3_ff, nl3_ff;
   // signed wheel products
   logic signed [56:0] wr_ff, wl_ff;
   // sum and difference
   logic signed [57:0] sum_ff, diff_ff;
   logic [56:0] msum_ff, mdiff_ff;
   logic        sneg6_ff, dneg6_ff, sneg7_ff, dneg7_ff, sneg8_ff, dneg8_ff;
   // partial products
   logic [63:0] ps_lo_ff, pd0_ff;
   logic [56:0] ps_hi_ff, pd2_ff;
   logic [39:0] pd1_ff;
   logic [32:0] pd3_ff;
   logic [88:0] ps_sum;
   logic [96:0] pd_sum;
   logic [SD_W-1:0]     sd_ff;
   logic [QUO_BITS-1:0] div_ff;

   always_comb begin
      ur_in = {{2{right_pulses[15]}}, right_pulses, 16'b0} +
              {{2{right_noise[31]}}, right_noise};
      ul_in = {{2{left_pulses[15]}}, left_pulses, 16'b0} +
              {{2{left_noise[31]}}, left_noise};
      prod_r = {33'b0, mrs_ff} * {32'b0, mur_ff};
      prod_l = {33'b0, mls_ff} * {32'b0, mul_ff};
      ps_sum = 89'(ps_lo_ff) + (89'(ps_hi_ff) << 32);
      pd_sum = 97'(pd0_ff) + (97'(pd1_ff) << 32) + (97'(pd2_ff) << 32) +
               (97'(pd3_ff) << 64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pass_ff[0] <= in_pass;
         for (int i = 1; i < 8; i++) begin
            pass_ff[i] <= pass_ff[i-1];
         end
         ur_ff <= ur_in;
         ul_ff <= ul_in;

         mur_ff <= ur_ff[33] ? 33'(-ur_ff) : ur_ff[32:0];
         mul_ff <= ul_ff[33] ? 33'(-ul_ff) : ul_ff[32:0];
         mrs_ff <= pass_ff[0].right_wheel_scale[31] ?
                   32'(-pass_ff[0].right_wheel_scale) : pass_ff[0].right_wheel_scale;
         mls_ff <= pass_ff[0].left_wheel_scale[31] ?
                   32'(-pass_ff[0].left_wheel_scale) : pass_ff[0].left_wheel_scale;
         nr2_ff <= ur_ff[33] ^ pass_ff[0].right_wheel_scale[31];
         nl2_ff <= ul_ff[33] ^ pass_ff[0].left_wheel_scale[31];

         pr_ff  <= prod_r[63:8];
         pl_ff  <= prod_l[63:8];
         nr3_ff <= nr2_ff;
         nl3_ff <= nl2_ff;

         wr_ff <= nr3_ff ? -$signed({1'b0, pr_ff}) : $signed({1'b0, pr_ff});
         wl_ff <= nl3_ff ? -$signed({1'b0, pl_ff}) : $signed({1'b0, pl_ff});

         sum_ff  <= {wr_ff[56], wr_ff} + {wl_ff[56], wl_ff};
         diff_ff <= {wr_ff[56], wr_ff} - {wl_ff[56], wl_ff};

         msum_ff  <= sum_ff[57] ? 57'(-sum_ff) : sum_ff[56:0];
         mdiff_ff <= diff_ff[57] ? 57'(-diff_ff) : diff_ff[56:0];
         sneg6_ff <= sum_ff[57];
         dneg6_ff <= diff_ff[57];

         ps_lo_ff <= {32'b0, msum_ff[31:0]} * {32'b0, distance_scale};
         ps_hi_ff <= {32'b0, msum_ff[56:32]} * {25'b0, distance_scale};
         pd0_ff   <= {32'b0, mdiff_ff[31:0]} * {32'b0, angle_scale[31:0]};
         pd1_ff   <= {8'b0, mdiff_ff[31:0]} * {32'b0, angle_scale[39:32]};
         pd2_ff   <= {32'b0, mdiff_ff[56:32]} * {25'b0, angle_scale[31:0]};
         pd3_ff   <= {8'b0, mdiff_ff[56:32]} * {25'b0, angle_scale[39:32]};
         sneg7_ff <= sneg6_ff;
         dneg7_ff <= dneg6_ff;

         sd_ff    <= ps_sum[88:40];
         div_ff   <= pd_sum[96:24];
         sneg8_ff <= sneg7_ff;
         dneg8_ff <= dneg7_ff;
      end
   end

   always_comb begin
      out_valid            = vld_ff[7];
      out_item.pass        = pass_ff[7];
      out_item.sd_mag      = sd_ff;
      out_item.sd_neg      = sneg8_ff;
      out_item.diff_neg    = dneg8_ff;
      out_item.new_heading = pass_ff[7].heading;
      out_dividend         = div_ff;
   end

endmodule

// ===== sv/odo_div.sv =====
`timescale 1ns / 1ps

module odo_div import odo_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  item_type            in_item,
   input  logic [QUO_BITS-1:0] in_dividend,
   output logic                out_valid,
   output item_type            out_item,
   output logic [31:0]         out_quotient
);

   logic                vld_ff  [QUO_BITS];
   item_type            item_ff [QUO_BITS];
   logic [30:0]         rem_ff  [QUO_BITS];
   logic [QUO_BITS-1:0] num_ff  [QUO_BITS];
   logic [31:0]         quo_ff  [QUO_BITS];

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
      logic                vld_src;
      item_type            item_src;
      logic [30:0]         rem_src, rem_in;
      logic [QUO_BITS-1:0] num_src;
      logic [31:0]         quo_src, trial;
      logic                ge;

      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign item_src = in_item;
         assign rem_src  = '0;
         assign num_src  = in_dividend;
         assign quo_src  = '0;
      end else begin : g_next
         assign vld_src  = vld_ff[i-1];
         assign item_src = item_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign num_src  = num_ff[i-1];
         assign quo_src  = quo_ff[i-1];
      end

      always_comb begin
         trial  = {rem_src, num_src[QUO_BITS-1]};
         ge     = trial >= {1'b0, item_src.pass.wheel_base};
         rem_in = ge ? 31'(trial - {1'b0, item_src.pass.wheel_base}) : trial[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[i] <= item_src;
            rem_ff[i]  <= rem_in;
            num_ff[i]  <= num_src << 1;
            quo_ff[i]  <= {quo_src[30:0], ge};
         end
      end
   end

   assign out_valid    = vld_ff[QUO_BITS-1];
   assign out_item     = item_ff[QUO_BITS-1];
   assign out_quotient = quo_ff[QUO_BITS-1];

endmodule

// ===== sv/odo_cordic.sv =====
`timescale 1ns / 1ps

module odo_cordic import odo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  item_type           in_item,
   input  logic [31:0]        in_quotient,
   output logic               out_valid,
   output item_type           out_item,
   output logic signed [33:0] out_x,
   output logic signed [33:0] out_y,
   output logic [1:0]         out_quad
);

   logic                  vld_ff  [CORDIC_STEPS+1];
   item_type              item_ff [CORDIC_STEPS+1];
   logic signed [33:0]    x_ff    [CORDIC_STEPS+1];
   logic signed [33:0]    y_ff    [CORDIC_STEPS+1];
   logic signed [32:0]    z_ff    [CORDIC_STEPS+1];
   logic [1:0]            quad_ff [CORDIC_STEPS+1];

   logic [31:0] turn, angle;
   item_type    item_in;

   always_comb begin
      turn                = in_item.diff_neg ? 32'(-in_quotient) : in_quotient;
      angle               = in_item.pass.heading + turn;
      item_in             = in_item;
      item_in.new_heading = angle + turn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= item_in;
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({3'b0, angle[29:0]});
         quad_ff[0] <= angle[31:30];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [33:0] dx, dy, x_in, y_in;
      logic signed [32:0] z_in, at;

      always_comb begin
         dx = x_ff[i] >>> i;
         dy = y_ff[i] >>> i;
         at = $signed({1'b0, atan_of(5'(i))});
         if (!z_ff[i][32]) begin
            x_in = x_ff[i] - dy;
            y_in = y_ff[i] + dx;
            z_in = z_ff[i] - at;
         end else begin
            x_in = x_ff[i] + dy;
            y_in = y_ff[i] - dx;
            z_in = z_ff[i] + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[i+1] <= item_ff[i];
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS];
   assign out_item  = item_ff[CORDIC_STEPS];
   assign out_x     = x_ff[CORDIC_STEPS];
   assign out_y     = y_ff[CORDIC_STEPS];
   assign out_quad  = quad_ff[CORDIC_STEPS];

endmodule

// ===== sv/odo_back.sv =====
`timescale 1ns / 1ps

module odo_back import odo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  item_type           in_item,
   input  logic signed [33:0] in_x,
   input  logic signed [33:0] in_y,
   input  logic [1:0]         in_quad,
   output logic               out_valid,
   output rsp_type            out_rsp
);

   logic [3:0] vld_ff;
   item_type   item_ff [3];

   logic signed [33:0] cv, sv;
   logic [32:0] cm_ff, sm_ff;
   logic        xneg1_ff, yneg1_ff, xneg2_ff, yneg2_ff, xneg3_ff, yneg3_ff;
   logic [57:0] xlo_ff, ylo_ff;
   logic [56:0] xhi_ff, yhi_ff;
   logic [81:0] xp, yp;
   logic [51:0] dxm_ff, dym_ff;
   logic signed [53:0] sx, sy;
   logic        sat_x, sat_y;
   rsp_type     rsp_in, rsp_ff;

   always_comb begin
      unique case (in_quad)
         QUAD_0: begin cv = in_x;  sv = in_y;  end
         QUAD_1: begin cv = -in_y; sv = in_x;  end
         QUAD_2: begin cv = -in_x; sv = -in_y; end
         QUAD_3: begin cv = in_y;  sv = -in_x; end
         default: begin cv = in_x; sv = in_y; end
      endcase
      xp = 82'(xlo_ff) + (82'(xhi_ff) << 25);
      yp = 82'(ylo_ff) + (82'(yhi_ff) << 25);

      sx = $signed({{22{item_ff[2].pass.pos_x[31]}}, item_ff[2].pass.pos_x}) +
           (xneg3_ff ? -$signed({2'b0, dxm_ff}) : $signed({2'b0, dxm_ff}));
      sy = $signed({{22{item_ff[2].pass.pos_y[31]}}, item_ff[2].pass.pos_y}) +
           (yneg3_ff ? -$signed({2'b0, dym_ff}) : $signed({2'b0, dym_ff}));
      sat_x = (sx[53:31] != '0) && (sx[53:31] != '1);
      sat_y = (sy[53:31] != '0) && (sy[53:31] != '1);

      rsp_in.out_right_scale = item_ff[2].pass.right_wheel_scale;
      rsp_in.out_left_scale  = item_ff[2].pass.left_wheel_scale;
      rsp_in.out_wheel_base  = item_ff[2].pass.wheel_base;
      if (item_ff[2].pass.wheel_base == '0) begin
         rsp_in.new_pos_x   = item_ff[2].pass.pos_x;
         rsp_in.new_pos_y   = item_ff[2].pass.pos_y;
         rsp_in.new_heading = item_ff[2].pass.heading;
         rsp_in.status      = STATUS_ZERO_BASE;
      end else begin
         rsp_in.new_pos_x   = sat_x ? (sx[53] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sx[31:0];
         rsp_in.new_pos_y   = sat_y ? (sy[53] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sy[31:0];
         rsp_in.new_heading = item_ff[2].new_heading;
         rsp_in.status      = (sat_x || sat_y) ? STATUS_SATURATED : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= in_item;
         item_ff[1] <= item_ff[0];
         item_ff[2] <= item_ff[1];

         cm_ff    <= cv[33] ? 33'(-cv) : cv[32:0];
         sm_ff    <= sv[33] ? 33'(-sv) : sv[32:0];
         xneg1_ff <= cv[33] ^ in_item.sd_neg;
         yneg1_ff <= sv[33] ^ in_item.sd_neg;

         xlo_ff   <= {25'b0, cm_ff} * {33'b0, item_ff[0].sd_mag[24:0]};
         xhi_ff   <= {24'b0, cm_ff} * {33'b0, item_ff[0].sd_mag[48:25]};
         ylo_ff   <= {25'b0, sm_ff} * {33'b0, item_ff[0].sd_mag[24:0]};
         yhi_ff   <= {24'b0, sm_ff} * {33'b0, item_ff[0].sd_mag[48:25]};
         xneg2_ff <= xneg1_ff;
         yneg2_ff <= yneg1_ff;

         dxm_ff   <= xp[81:30];
         dym_ff   <= yp[81:30];
         xneg3_ff <= xneg2_ff;
         yneg3_ff <= yneg2_ff;

         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_rsp   = rsp_ff;

endmodule

// ===== verif/differential_drive_odometry_update_tb.sv =====
`timescale 1ns / 1ps

module differential_drive_odometry_update_tb;
   import odo_pkg::*;

   localparam logic [3:0] ADDR_DIST_SCALE  = 4'd0;
   localparam logic [3:0] ADDR_ANGLE_SCALE = 4'd8;
   localparam int DRAIN_CYCLES = 130;

   localparam logic [31:0] ARCTAN_STEP [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] heading;
      logic [31:0] right_wheel_scale;
      logic [31:0] left_wheel_scale;
      logic [30:0] wheel_base;
      logic [15:0] right_pulses;
      logic [15:0] left_pulses;
      logic [31:0] right_noise;
      logic [31:0] left_noise;
   } vehicle_state_type;

   typedef struct {
      logic [31:0] new_pos_x;
      logic [31:0] new_pos_y;
      logic [31:0] new_heading;
      logic [31:0] out_right_scale;
      logic [31:0] out_left_scale;
      logic [30:0] out_wheel_base;
      logic [1:0]  status;
   } pose_update_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   logic [31:0]  dist_scale_q  = DIST_SCALE_RESET;
   logic [39:0]  angle_scale_q = ANGLE_SCALE_RESET;

   pose_update_type expected_poses[$];
   int           mismatch_cnt = 0;
   int           sent_cnt = 0;
   int           checked_cnt = 0;
   int           setting_cnt = 0;
   bit           idling_on = 1'b0;
   int           rsp_stall = 0;

   differential_drive_odometry_update u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [127:0] mag128(logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   // |a|*b >> n truncated toward zero, sign of a restored
   function automatic logic signed [127:0] scaled_trunc(logic signed [127:0] a,
                                                       logic [127:0] b, int n);
      logic [127:0] r;
      r = (mag128(a) * b) >> n;
      return a < 0 ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [127:0] wheel_travel(logic signed [127:0] sc,
                                                       logic signed [127:0] u);
      logic [127:0] m;
      m = (mag128(sc) * mag128(u)) >> 8;
      return ((sc < 0) != (u < 0)) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [127:0] clamp32(logic signed [127:0] v, ref bit hit);
      if (v > 128'sd2147483647) begin
         hit = 1'b1;
         return 128'sd2147483647;
      end
      if (v < -128'sd2147483648) begin
         hit = 1'b1;
         return -128'sd2147483648;
      end
      return v;
   endfunction

   function automatic pose_update_type predict_pose(vehicle_state_type s);
      pose_update_type r;
      logic signed [127:0] ur, ul, wr, wl, sum, diff, sd, cs, sn, step_x, step_y, nx, ny;
      logic [127:0] prod, q;
      logic [31:0] turn, ang;
      longint cx, cy, cz, dx, dy;
      bit hit;
      r.new_pos_x       = s.pos_x;
      r.new_pos_y       = s.pos_y;
      r.new_heading     = s.heading;
      r.out_right_scale = s.right_wheel_scale;
      r.out_left_scale  = s.left_wheel_scale;
      r.out_wheel_base  = s.wheel_base;
      r.status          = STATUS_OK;
      if (s.wheel_base == 0) begin
         r.status = STATUS_ZERO_BASE;
         return r;
      end
      ur = $signed(s.right_pulses);
      ur = ur * 65536 + $signed(s.right_noise);
      ul = $signed(s.left_pulses);
      ul = ul * 65536 + $signed(s.left_noise);
      wr = wheel_travel($signed(s.right_wheel_scale), ur);
      wl = wheel_travel($signed(s.left_wheel_scale), ul);
      sum  = wr + wl;
      diff = wr - wl;
      sd = scaled_trunc(sum, {96'd0, dist_scale_q}, 40);
      prod = mag128(diff) * {88'd0, angle_scale_q};
      q = prod / ({97'd0, s.wheel_base} << 24);
      turn = diff < 0 ? -q[31:0] : q[31:0];
      ang = s.heading + turn;
      r.new_heading = s.heading + turn + turn;
      cx = CORDIC_GAIN;
      cy = 0;
      cz = longint'(ang[29:0]);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cy >>> (i % 32);
         dy = cx >>> (i % 32);
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= longint'(ARCTAN_STEP[i % 32]);
         end else begin
            cx += dx; cy -= dy; cz += longint'(ARCTAN_STEP[i % 32]);
         end
      end
      case (ang[31:30])
         QUAD_0: begin cs = cx;  sn = cy;  end
         QUAD_1: begin cs = -cy; sn = cx;  end
         QUAD_2: begin cs = -cx; sn = -cy; end
         default: begin cs = cy; sn = -cx; end
      endcase
      step_x = scaled_trunc(cs, mag128(sd), 30);
      step_y = scaled_trunc(sn, mag128(sd), 30);
      if (sd < 0) begin
         step_x = -step_x;
         step_y = -step_y;
      end
      hit = 1'b0;
      nx = clamp32($signed(s.pos_x) + step_x, hit);
      ny = clamp32($signed(s.pos_y) + step_y, hit);
      r.new_pos_x = nx[31:0];
      r.new_pos_y = ny[31:0];
      if (hit) r.status = STATUS_SATURATED;
      return r;
   endfunction

   function automatic logic [287:0] pack_state(vehicle_state_type s);
      return {1'b0, s.left_noise, s.right_noise, s.left_pulses, s.right_pulses,
              s.wheel_base, s.left_wheel_scale, s.right_wheel_scale, s.heading,
              s.pos_y, s.pos_x};
   endfunction

   function automatic vehicle_state_type random_state();
      vehicle_state_type s;
      int mode;
      mode = $urandom_range(0, 9);
      s.pos_x             = $urandom;
      s.pos_y             = $urandom;
      s.heading           = $urandom;
      s.right_wheel_scale = $urandom;
      s.left_wheel_scale  = $urandom;
      s.wheel_base        = 31'($urandom);
      s.right_pulses      = 16'($urandom);
      s.left_pulses       = 16'($urandom);
      s.right_noise       = $urandom;
      s.left_noise        = $urandom;
      if (mode == 1) begin
         s.wheel_base = '0;
      end else if (mode == 2) begin
         s.pos_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                        : 32'h8000_0000 + $urandom_range(0, 255);
         s.pos_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                        : 32'h8000_0000 + $urandom_range(0, 255);
      end else if (mode == 3) begin
         s.wheel_base = 31'($urandom_range(1, 64));
      end else if (mode >= 4) begin
         s.right_wheel_scale = $urandom_range(32'h0000_4000, 32'h0004_0000);
         s.left_wheel_scale  = $urandom_range(32'h0000_4000, 32'h0004_0000);
         s.wheel_base        = 31'($urandom_range(32'h0000_8000, 32'h0040_0000));
         s.right_pulses      = 16'($urandom_range(0, 2000) - 1000);
         s.left_pulses       = 16'($urandom_range(0, 2000) - 1000);
         s.right_noise       = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         s.left_noise        = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      end
      return s;
   endfunction

   task automatic send_state(vehicle_state_type s);
      req_tdata  <= pack_state(s);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_poses.push_back(predict_pose(s));
      sent_cnt++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [3:0] addr, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_DIST_SCALE) dist_scale_q = value[31:0];
      else if (addr == ADDR_ANGLE_SCALE) angle_scale_q = value[39:0];
   endtask

   task automatic test_directed();
      vehicle_state_type s;
      vehicle_state_type base;
      base.pos_x = 32'h0010_0000;          base.pos_y = 32'hFFF0_0000;
      base.heading = 32'h1000_0000;        base.right_wheel_scale = 32'h0001_0000;
      base.left_wheel_scale = 32'h0001_0000;
      base.wheel_base = 31'h0002_0000;     base.right_pulses = 16'd800;
      base.left_pulses = 16'd400;          base.right_noise = 32'h0000_8000;
      base.left_noise = 32'hFFFF_8000;
      send_state(base);
      // zero wheel base
      s = base; s.wheel_base = '0; send_state(s);
      // each heading quadrant, turning both ways
      for (int k = 0; k < 4; k++) begin
         s = base; s.heading = 32'(k) << 30; send_state(s);
         s.right_pulses = 16'hFE70; send_state(s);
      end
      // all fields at the top and the bottom of their ranges
      s.pos_x = 32'h7FFF_FFFF; s.pos_y = 32'h7FFF_FFFF; s.heading = 32'hFFFF_FFFF;
      s.right_wheel_scale = 32'h7FFF_FFFF; s.left_wheel_scale = 32'h7FFF_FFFF;
      s.wheel_base = 31'h7FFF_FFFF; s.right_pulses = 16'h7FFF; s.left_pulses = 16'h7FFF;
      s.right_noise = 32'h7FFF_FFFF; s.left_noise = 32'h7FFF_FFFF;
      send_state(s);
      s.pos_x = 32'h8000_0000; s.pos_y = 32'h8000_0000; s.heading = '0;
      s.right_wheel_scale = 32'h8000_0000; s.left_wheel_scale = 32'h8000_0000;
      s.wheel_base = 31'd1; s.right_pulses = 16'h8000; s.left_pulses = 16'h8000;
      s.right_noise = 32'h8000_0000; s.left_noise = 32'h8000_0000;
      send_state(s);
      s.left_pulses = 16'h7FFF; s.left_noise = 32'h7FFF_FFFF; send_state(s);
      // position saturation in both directions
      s = base; s.pos_x = 32'h7FFF_FFF0; s.heading = '0;
      s.right_wheel_scale = 32'h7FFF_0000; s.left_wheel_scale = 32'h7FFF_0000;
      send_state(s);
      s.pos_x = 32'h8000_0010; s.pos_y = 32'h8000_0010; s.heading = 32'hA000_0000;
      send_state(s);
      // pulses cancelled by noise
      s = base; s.right_pulses = 16'd1; s.right_noise = 32'hFFFF_0000; send_state(s);
      drain_pipeline();
   endtask

   task automatic test_register_settings();
      logic [31:0] ds_vals [4] = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, DIST_SCALE_RESET};
      logic [39:0] as_vals [4] = '{40'd0, 40'hFF_FFFF_FFFF, 40'h00_1234_5678,
                                   ANGLE_SCALE_RESET};
      for (int k = 0; k < 4; k++) begin
         write_csr(ADDR_DIST_SCALE, {32'd0, ds_vals[k]});
         write_csr(ADDR_ANGLE_SCALE, {24'd0, as_vals[(k + 1) % 4]});
         setting_cnt++;
         repeat (40) send_state(random_state());
         drain_pipeline();
      end
   endtask

   task automatic test_random_traffic(int count, bit with_idling);
      idling_on = with_idling;
      repeat (count) send_state(random_state());
      drain_pipeline();
   endtask

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pose_update_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_poses.size() == 0) begin
            $error("unexpected transaction on rsp: %h", rsp_tdata);
            mismatch_cnt++;
         end else begin
            e = expected_poses.pop_front();
            checked_cnt++;
            if (rsp_tdata[31:0] !== e.new_pos_x) begin
               $error("new_pos_x expected %h actual %h", e.new_pos_x, rsp_tdata[31:0]);
               mismatch_cnt++;
            end
            if (rsp_tdata[63:32] !== e.new_pos_y) begin
               $error("new_pos_y expected %h actual %h", e.new_pos_y, rsp_tdata[63:32]);
               mismatch_cnt++;
            end
            if (rsp_tdata[95:64] !== e.new_heading) begin
               $error("new_heading expected %h actual %h", e.new_heading, rsp_tdata[95:64]);
               mismatch_cnt++;
            end
            if (rsp_tdata[127:96] !== e.out_right_scale) begin
               $error("out_right_scale expected %h actual %h", e.out_right_scale,
                      rsp_tdata[127:96]);
               mismatch_cnt++;
            end
            if (rsp_tdata[159:128] !== e.out_left_scale) begin
               $error("out_left_scale expected %h actual %h", e.out_left_scale,
                      rsp_tdata[159:128]);
               mismatch_cnt++;
            end
            if (rsp_tdata[190:160] !== e.out_wheel_base) begin
               $error("out_wheel_base expected %h actual %h", e.out_wheel_base,
                      rsp_tdata[190:160]);
               mismatch_cnt++;
            end
            if (rsp_tdata[192:191] !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_tdata[192:191]);
               mismatch_cnt++;
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("timeout with %0d transactions outstanding", expected_poses.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_settings();
      test_random_traffic(1050, 1'b1);
      test_random_traffic(150, 1'b0);
      $display("covered %0d state updates (%0d checked) over %0d register settings",
               sent_cnt, checked_cnt, setting_cnt + 1);
      $display("with zero base, saturation, all heading quadrants and random backpressure");
      if (mismatch_cnt == 0 && expected_poses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
